/* src/imufhm_pkg.sv */
package imufhm_pkg;

  // Config register indexes
  typedef enum logic [2:0] {
    REG_FAIL_LIMIT   = 3'd0,
    REG_FAST_RETRY   = 3'd1,
    REG_SLOW_RETRY   = 3'd2,
    REG_FAST_COUNT   = 3'd3,
    REG_RANGE_LIMIT  = 3'd4
  } reg_index_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [7:0]  FAIL_LIMIT_RST  = 8'd5;
  localparam logic [15:0] FAST_RETRY_RST  = 16'd100;
  localparam logic [15:0] SLOW_RETRY_RST  = 16'd500;
  localparam logic [7:0]  FAST_COUNT_RST  = 8'd5;
  localparam logic [14:0] RANGE_LIMIT_RST = 15'd29500;
  localparam logic [7:0]  SAT_MAX         = 8'd255;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_DATA = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_IO_ERR  = 3'd3,
    ST_BAD_ID  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    INIT_OK      = 2'd0,
    INIT_IO_ERR  = 2'd1,
    INIT_BAD_ID  = 2'd2,
    INIT_TIMEOUT = 2'd3
  } init_code_t;

  typedef enum logic [1:0] {
    RD_OK      = 2'd0,
    RD_TIMEOUT = 2'd1,
    RD_IO_ERR  = 2'd2,
    RD_OTHER   = 2'd3
  } read_code_t;

  typedef enum logic [1:0] {
    STG_NONE  = 2'd0,
    STG_READ  = 2'd1,
    STG_ZERO  = 2'd2,
    STG_RANGE = 2'd3
  } stage_t;

  localparam int unsigned NUM_WORDS = 7;
  localparam int unsigned TEMP_WORD = 3;
  localparam int unsigned IN_W      = 152;
  localparam int unsigned OUT_W     = 136;

  typedef struct packed {
    logic [7:0]  fail_limit;
    logic [15:0] fast_retry_ms;
    logic [15:0] slow_retry_ms;
    logic [7:0]  fast_retry_count;
    logic [14:0] range_limit;
  } cfg_t;

  // words: accel x/y/z, temp, gyro x/y/z (index 0 first)
  typedef struct packed {
    logic [31:0]                 now_ms;
    logic                        reinit_req;
    init_code_t                  init_outcome;
    read_code_t                  read_outcome;
    logic [NUM_WORDS-1:0][15:0]  words;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        init_tried;
    stage_t      fail_stage;
    logic [31:0] sample_seq;
    logic [31:0] sample_stamp;
    logic [31:0] errors_seen;
    logic [31:0] inits_done;
  } result_t;

  typedef struct packed {
    logic        pending_reinit;
    logic        ready;
    logic [7:0]  init_fails;
    logic [7:0]  link_fails;
    logic [31:0] seq_count;
    logic [31:0] stamp_reg;
    logic [31:0] error_total;
    logic [31:0] init_total;
  } mon_state_t;

endpackage

/* src/imu_frame_health_monitor_unit.sv */
// IMU frame health monitor.
// Input stream s_*: one request per sensor poll (time, reinit request, init and
// read outcomes, seven raw words). Output stream m_*: exactly one result per
// request, in order (status, init flag, failure stage, sequence, stamp, counters).
// Config port cfg_*: write-only, one register per cycle at cfg_wr_en; write
// only while no request is in flight.
// Pipeline: an accepted request is held in the input register, then moves into the
// result register, where m_tvalid goes high and the result can be taken.
// Throughput: one request per cycle while m_tready is high; the monitor state
// (reinit, backoff, fail counters, sequence) is updated in the same cycle as the
// request moves from the input register into the result register.
// Stall: when m_tready is low the result register holds; the input register
// still takes one more request, then s_tready drops until the result is taken.
// Reset (rst, synchronous): both stages empty, counters cleared, config back to
// defaults, and a reinit pending so the first poll attempts an init.
// TIME_BITS sets the width of the retry deadline compare (time wraps there).
module imu_frame_health_monitor_unit import imufhm_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [31:0] now_ms, [32] reinit_req, [34:33] init_outcome, [36:35] read_outcome,
  // [52:37] accel_x, [68:53] accel_y, [84:69] accel_z, [100:85] temp_raw,
  // [116:101] gyro_x, [132:117] gyro_y, [148:133] gyro_z, [151:149] zero
  input  logic [IN_W-1:0]        s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [2:0] status, [3] init_tried, [5:4] fail_stage, [37:6] sample_seq,
  // [69:38] sample_stamp, [101:70] errors_seen, [133:102] inits_done, [135:134] zero
  output logic [OUT_W-1:0]       m_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t                 cfg;
  item_t                in_item;
  item_t                s_item;
  logic                 in_valid;
  mon_state_t           st;
  mon_state_t           st_next;
  logic [TIME_BITS-1:0] retry_due;
  logic [TIME_BITS-1:0] retry_due_next;
  result_t              res_next;
  result_t              res;
  logic                 out_valid;
  logic                 advance;

  // Unpack the request: field order matches the tdata layout above.
  always_comb begin
    s_item.now_ms       = s_tdata[31:0];
    s_item.reinit_req   = s_tdata[32];
    s_item.init_outcome = init_code_t'(s_tdata[34:33]);
    s_item.read_outcome = read_code_t'(s_tdata[36:35]);
    for (int i = 0; i < NUM_WORDS; i++) begin
      s_item.words[i] = s_tdata[37 + 16*i +: 16];
    end
  end

  // Handshake: a request advances when the result register is free or drains.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fail_limit       <= FAIL_LIMIT_RST;
      cfg.fast_retry_ms    <= FAST_RETRY_RST;
      cfg.slow_retry_ms    <= SLOW_RETRY_RST;
      cfg.fast_retry_count <= FAST_COUNT_RST;
      cfg.range_limit      <= RANGE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_addr))
        REG_FAIL_LIMIT:  cfg.fail_limit       <= cfg_wdata[7:0];
        REG_FAST_RETRY:  cfg.fast_retry_ms    <= cfg_wdata;
        REG_SLOW_RETRY:  cfg.slow_retry_ms    <= cfg_wdata;
        REG_FAST_COUNT:  cfg.fast_retry_count <= cfg_wdata[7:0];
        REG_RANGE_LIMIT: cfg.range_limit      <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_item;
    end
  end

  imufhm_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .cfg            (cfg),
    .item           (in_item),
    .st             (st),
    .retry_due      (retry_due),
    .st_next        (st_next),
    .retry_due_next (retry_due_next),
    .res            (res_next)
  );

  // Monitor state: updated once per request, as it moves to the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.pending_reinit <= 1'b1;
      st.ready          <= 1'b0;
      st.init_fails     <= '0;
      st.link_fails     <= '0;
      st.seq_count      <= '0;
      st.stamp_reg      <= '0;
      st.error_total    <= '0;
      st.init_total     <= '0;
      retry_due         <= '0;
    end else if (advance) begin
      st        <= st_next;
      retry_due <= retry_due_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {2'b00, res.inits_done, res.errors_seen, res.sample_stamp,
                    res.sample_seq, res.fail_stage, res.init_tried, res.status};

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stage empty but request refused");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");

  a_ok_has_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.status == ST_OK |-> res.sample_seq != '0)
    else $error("good sample with zero sequence");

  a_stage_not_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.fail_stage != STG_NONE |-> res.status != ST_OK)
    else $error("failure stage reported with ok status");

  a_tried_no_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.init_tried && res.status == ST_OK |-> res.sample_seq == 32'd1)
    else $error("sequence not restarted after init");

endmodule

/* src/imufhm_step.sv */
module imufhm_step import imufhm_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  cfg_t                 cfg,
  input  item_t                item,
  input  mon_state_t           st,
  input  logic [TIME_BITS-1:0] retry_due,
  output mon_state_t           st_next,
  output logic [TIME_BITS-1:0] retry_due_next,
  output result_t              res
);

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] diff;
  logic                 pend;
  logic                 waiting;
  logic                 attempt;
  logic                 init_ok;
  logic [7:0]           init_fails_inc;
  logic [15:0]          delay;
  logic                 ready_eff;
  logic                 go;
  logic [7:0]           link_base;
  logic [7:0]           link_inc;
  logic                 all_zero;
  logic                 too_wide;
  logic signed [16:0]   lim_pos;
  logic signed [16:0]   lim_neg;
  logic signed [16:0]   v;
  stage_t               stage;
  status_t              init_status;
  status_t              chk_status;
  logic [31:0]          seq_inc;

  always_comb begin
    now_t   = TIME_BITS'(item.now_ms);
    diff    = now_t - retry_due;
    pend    = st.pending_reinit | item.reinit_req;
    waiting = pend && (retry_due != '0) && diff[TIME_BITS-1];
    attempt = pend && !waiting;
    init_ok = (item.init_outcome == INIT_OK);

    init_fails_inc = (st.init_fails == SAT_MAX) ? st.init_fails : st.init_fails + 8'd1;
    delay = (init_fails_inc <= cfg.fast_retry_count) ? cfg.fast_retry_ms : cfg.slow_retry_ms;

    unique case (item.init_outcome)
      INIT_IO_ERR: init_status = ST_IO_ERR;
      INIT_BAD_ID: init_status = ST_BAD_ID;
      INIT_TIMEOUT: init_status = ST_TIMEOUT;
      default: init_status = ST_OK;
    endcase

    ready_eff = attempt ? init_ok : st.ready;
    go        = !waiting && ready_eff;

    // frame checks: six axes against the range limit, temperature excluded
    lim_pos  = $signed({2'b00, cfg.range_limit});
    lim_neg  = -lim_pos;
    all_zero = 1'b1;
    too_wide = 1'b0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      v = $signed({item.words[i][15], item.words[i]});
      if (item.words[i] != 16'd0) all_zero = 1'b0;
      if (i != TEMP_WORD && (v > lim_pos || v < lim_neg)) too_wide = 1'b1;
    end

    if (item.read_outcome != RD_OK) begin
      stage = STG_READ;
    end else if (all_zero) begin
      stage = STG_ZERO;
    end else if (too_wide) begin
      stage = STG_RANGE;
    end else begin
      stage = STG_NONE;
    end

    case (stage)
      STG_READ: chk_status = (item.read_outcome == RD_TIMEOUT) ? ST_TIMEOUT : ST_IO_ERR;
      STG_NONE: chk_status = ST_OK;
      default:  chk_status = ST_IO_ERR;
    endcase

    // defaults: nothing changes
    st_next        = st;
    retry_due_next = retry_due;
    st_next.pending_reinit = pend;
    res.status     = ST_NO_DATA;
    res.init_tried = attempt;
    res.fail_stage = STG_NONE;

    if (attempt) begin
      st_next.ready      = init_ok;
      st_next.seq_count  = '0;
      st_next.stamp_reg  = '0;
      st_next.link_fails = '0;
      st_next.init_total = st.init_total + 32'd1;
      if (init_ok) begin
        st_next.pending_reinit = 1'b0;
        st_next.init_fails     = '0;
        retry_due_next         = '0;
      end else begin
        st_next.pending_reinit = 1'b1;
        st_next.init_fails     = init_fails_inc;
        retry_due_next         = now_t + TIME_BITS'(delay);
        res.status             = init_status;
      end
    end

    link_base = attempt ? 8'd0 : st.link_fails;
    link_inc  = (link_base == SAT_MAX) ? link_base : link_base + 8'd1;
    seq_inc   = st_next.seq_count + 32'd1;

    if (go) begin
      res.fail_stage = stage;
      res.status     = chk_status;
      if (stage != STG_NONE) begin
        st_next.error_total = st.error_total + 32'd1;
        if (stage == STG_READ || stage == STG_ZERO) begin
          st_next.link_fails = link_inc;
          if (link_inc >= cfg.fail_limit) begin
            st_next.ready          = 1'b0;
            st_next.pending_reinit = 1'b1;
            retry_due_next         = now_t + TIME_BITS'(cfg.fast_retry_ms);
          end
        end
      end else begin
        st_next.seq_count  = (seq_inc == '0) ? 32'd1 : seq_inc;
        st_next.stamp_reg  = 32'(now_t);
        st_next.link_fails = '0;
      end
    end

    res.sample_seq   = st_next.seq_count;
    res.sample_stamp = st_next.stamp_reg;
    res.errors_seen  = st_next.error_total;
    res.inits_done   = st_next.init_total;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench import imufhm_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 6;     // two-stage pipe plus margin

  // one directed row: the request, and a hand-typed result where it is obvious
  typedef struct packed {
    item_t   poll;
    logic    typed;
    result_t want;
  } poll_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_W-1:0]       m_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // shadow config, starts at reset defaults
  logic [7:0]  lim_fail  = FAIL_LIMIT_RST;
  logic [15:0] dly_fast  = FAST_RETRY_RST;
  logic [15:0] dly_slow  = SLOW_RETRY_RST;
  logic [7:0]  cnt_fast  = FAST_COUNT_RST;
  logic [14:0] lim_range = RANGE_LIMIT_RST;

  // shadow monitor state; a reinit is pending out of reset
  logic        want_reinit = 1'b1;
  logic        sensor_up   = 1'b0;
  logic [31:0] retry_at    = '0;
  logic [7:0]  init_miss   = '0;
  logic [7:0]  link_miss   = '0;
  logic [31:0] seq_no      = '0;
  logic [31:0] last_stamp  = '0;
  logic [31:0] err_cnt     = '0;
  logic [31:0] init_cnt    = '0;

  result_t     reports_due[$];     // expected results, oldest first
  poll_row_t   directed_rows[$];
  result_t     got_report;
  result_t     due_report;
  int          mismatches = 0;
  int          stuck_cycles = 0;
  logic        quiet = 1'b0;        // no random idling on either side
  logic        init_storm = 1'b0;   // every init attempt fails
  logic [31:0] clock_ms = 32'd1000; // running time for random polls

  always #2 clk = ~clk;

  imu_frame_health_monitor_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Predicts the report for one poll and advances the shadow state.
  // Order: reinit/backoff first, then ready gate, then frame checks.
  function automatic result_t health_report(item_t it);
    result_t     r;
    logic [31:0] diff;
    logic [15:0] delay;
    logic        go;
    logic        wide;
    int          v;
    int          lim;
    r.status     = ST_NO_DATA;
    r.init_tried = 1'b0;
    r.fail_stage = STG_NONE;
    go = 1'b1;
    if (it.reinit_req) want_reinit = 1'b1;
    if (want_reinit) begin
      // wrap-safe: still waiting while now - due is negative; due of zero never waits
      diff = it.now_ms - retry_at;
      if (retry_at != 0 && diff[31]) begin
        go = 1'b0;
      end else begin
        r.init_tried = 1'b1;
        want_reinit  = 1'b0;
        sensor_up    = 1'b0;
        seq_no       = '0;
        last_stamp   = '0;
        link_miss    = '0;
        init_cnt     = init_cnt + 1;
        if (it.init_outcome != INIT_OK) begin
          if (init_miss != SAT_MAX) init_miss = init_miss + 8'd1;
          delay       = (init_miss <= cnt_fast) ? dly_fast : dly_slow;
          want_reinit = 1'b1;
          retry_at    = it.now_ms + delay;
          case (it.init_outcome)
            INIT_IO_ERR: r.status = ST_IO_ERR;
            INIT_BAD_ID: r.status = ST_BAD_ID;
            default:     r.status = ST_TIMEOUT;
          endcase
          go = 1'b0;
        end else begin
          sensor_up = 1'b1;
          retry_at  = '0;
          init_miss = '0;
        end
      end
    end
    if (go && !sensor_up) go = 1'b0;
    if (go) begin
      // temperature word is exempt from the range check
      wide = 1'b0;
      lim  = lim_range;
      for (int i = 0; i < NUM_WORDS; i++) begin
        v = $signed(it.words[i]);
        if (i != TEMP_WORD && (v > lim || v < -lim)) wide = 1'b1;
      end
      if (it.read_outcome != RD_OK) begin
        r.fail_stage = STG_READ;
        r.status     = (it.read_outcome == RD_TIMEOUT) ? ST_TIMEOUT : ST_IO_ERR;
      end else if (it.words == '0) begin
        r.fail_stage = STG_ZERO;
        r.status     = ST_IO_ERR;
      end else if (wide) begin
        r.fail_stage = STG_RANGE;
        r.status     = ST_IO_ERR;
      end
      if (r.fail_stage != STG_NONE) begin
        err_cnt = err_cnt + 1;
        // only link-level failures count toward a forced reinit
        if (r.fail_stage != STG_RANGE) begin
          if (link_miss != SAT_MAX) link_miss = link_miss + 8'd1;
          if (link_miss >= lim_fail) begin
            sensor_up   = 1'b0;
            want_reinit = 1'b1;
            retry_at    = it.now_ms + dly_fast;
          end
        end
      end else begin
        seq_no = seq_no + 1;
        if (seq_no == 0) seq_no = 1;  // sequence skips zero
        last_stamp = it.now_ms;
        link_miss  = '0;
        r.status   = ST_OK;
      end
    end
    r.sample_seq   = seq_no;
    r.sample_stamp = last_stamp;
    r.errors_seen  = err_cnt;
    r.inits_done   = init_cnt;
    return r;
  endfunction

  // words[0] is accel_x, up to gyro_z
  function automatic logic [NUM_WORDS-1:0][15:0] words7(int ax, int ay, int az, int t,
                                                        int gx, int gy, int gz);
    return {16'(gz), 16'(gy), 16'(gx), 16'(t), 16'(az), 16'(ay), 16'(ax)};
  endfunction

  function automatic item_t poll(logic [31:0] now, logic rq, init_code_t io,
                                 read_code_t ro, logic [NUM_WORDS-1:0][15:0] w);
    item_t it;
    it.now_ms       = now;
    it.reinit_req   = rq;
    it.init_outcome = io;
    it.read_outcome = ro;
    it.words        = w;
    return it;
  endfunction

  // Mostly plausible polls: time moves forward, most inits and reads succeed,
  // frames mostly in range; the rest are zero frames, wild words, time jumps.
  function automatic item_t random_poll();
    item_t it;
    int    pick;
    int    lim;
    int    v;
    int    k;
    pick = $urandom_range(99);
    if (pick < 80) clock_ms = clock_ms + $urandom_range(1, 40);
    else if (pick < 92) clock_ms = clock_ms + $urandom_range(0, 70000);
    else if (pick < 97) clock_ms = $urandom();
    it.now_ms     = clock_ms;
    it.reinit_req = ($urandom_range(99) < 3);
    if (init_storm || $urandom_range(99) < 20)
      it.init_outcome = init_code_t'($urandom_range(1, 3));
    else
      it.init_outcome = INIT_OK;
    if ($urandom_range(99) < 18) it.read_outcome = read_code_t'($urandom_range(1, 3));
    else it.read_outcome = RD_OK;
    lim  = lim_range;
    pick = $urandom_range(99);
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (pick < 6) begin
        it.words[i] = '0;
      end else if (pick < 20) begin
        it.words[i] = 16'($urandom());
      end else begin
        v = int'($urandom_range(0, 2 * lim)) - lim;
        it.words[i] = 16'(v);
      end
    end
    // push one accel/gyro word just past the limit
    if (pick >= 20 && pick < 34) begin
      k = $urandom_range(0, NUM_WORDS - 2);
      if (k >= TEMP_WORD) k++;
      v = $urandom_range(0, 1) ? lim + 1 : -(lim + 1);
      it.words[k] = 16'(v);
    end
    return it;
  endfunction

  // Drive one request and hold it until the handshake; the expected report is
  // queued at the accepting edge.
  task automatic send_poll(item_t it, logic typed, result_t want);
    result_t due;
    while (!quiet && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, it.words, it.read_outcome, it.init_outcome, it.reinit_req,
                 it.now_ms};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = health_report(it);
    if (typed) due = want;
    reports_due.push_back(due);
  endtask

  // stop sending and let the pipe empty before any config write
  task automatic drain();
    s_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FAIL_LIMIT:  lim_fail  = val[7:0];
      REG_FAST_RETRY:  dly_fast  = val;
      REG_SLOW_RETRY:  dly_slow  = val;
      REG_FAST_COUNT:  cnt_fast  = val[7:0];
      REG_RANGE_LIMIT: lim_range = val[14:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [7:0] fl, logic [15:0] fast, logic [15:0] slow,
                           logic [7:0] cnt, logic [14:0] rng);
    set_reg(REG_FAIL_LIMIT, 16'(fl));
    set_reg(REG_FAST_RETRY, fast);
    set_reg(REG_SLOW_RETRY, slow);
    set_reg(REG_FAST_COUNT, 16'(cnt));
    set_reg(REG_RANGE_LIMIT, 16'(rng));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) send_poll(random_poll(), 1'b0, '0);
  endtask

  // Result side: random back-pressure, compare each accepted result with the
  // oldest expectation field by field.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      got_report.status       = status_t'(m_tdata[2:0]);
      got_report.init_tried   = m_tdata[3];
      got_report.fail_stage   = stage_t'(m_tdata[5:4]);
      got_report.sample_seq   = m_tdata[37:6];
      got_report.sample_stamp = m_tdata[69:38];
      got_report.errors_seen  = m_tdata[101:70];
      got_report.inits_done   = m_tdata[133:102];
      if (reports_due.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        due_report = reports_due.pop_front();
        if (got_report.status !== due_report.status) begin
          $error("status: expected %0d, got %0d", due_report.status, got_report.status);
          mismatches++;
        end
        if (got_report.init_tried !== due_report.init_tried) begin
          $error("init_tried: expected %0d, got %0d", due_report.init_tried,
                 got_report.init_tried);
          mismatches++;
        end
        if (got_report.fail_stage !== due_report.fail_stage) begin
          $error("fail_stage: expected %0d, got %0d", due_report.fail_stage,
                 got_report.fail_stage);
          mismatches++;
        end
        if (got_report.sample_seq !== due_report.sample_seq) begin
          $error("sample_seq: expected %0d, got %0d", due_report.sample_seq,
                 got_report.sample_seq);
          mismatches++;
        end
        if (got_report.sample_stamp !== due_report.sample_stamp) begin
          $error("sample_stamp: expected %0d, got %0d", due_report.sample_stamp,
                 got_report.sample_stamp);
          mismatches++;
        end
        if (got_report.errors_seen !== due_report.errors_seen) begin
          $error("errors_seen: expected %0d, got %0d", due_report.errors_seen,
                 got_report.errors_seen);
          mismatches++;
        end
        if (got_report.inits_done !== due_report.inits_done) begin
          $error("inits_done: expected %0d, got %0d", due_report.inits_done,
                 got_report.inits_done);
          mismatches++;
        end
      end
    end
    m_tready <= rst ? 1'b0 : (quiet || $urandom_range(99) >= 8);
  end

  // watchdog: any handshake on either side counts as progress
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("imu_frame_health_monitor_unit: mismatch");
      $finish;
    end
  end

  initial begin
    // Directed rows at reset config (limit 5, fast 100, slow 500, count 5,
    // range 29500). Typed results only where the outcome is plain.
    directed_rows.push_back('{poll(32'd10, 1'b0, INIT_IO_ERR, RD_OK,
                              words7(100, -200, 16384, 2500, -7, 3, -1)),
                              1'b1, result_t'{ST_IO_ERR, 1'b1, STG_NONE, 32'd0, 32'd0,
                                              32'd0, 32'd1}});
    // still before the retry time
    directed_rows.push_back('{poll(32'd50, 1'b0, INIT_OK, RD_OK,
                              words7(100, -200, 16384, 2500, -7, 3, -1)),
                              1'b1, result_t'{ST_NO_DATA, 1'b0, STG_NONE, 32'd0, 32'd0,
                                              32'd0, 32'd1}});
    directed_rows.push_back('{poll(32'd110, 1'b0, INIT_BAD_ID, RD_OK,
                              words7(100, -200, 16384, 2500, -7, 3, -1)),
                              1'b1, result_t'{ST_BAD_ID, 1'b1, STG_NONE, 32'd0, 32'd0,
                                              32'd0, 32'd2}});
    // half a time range past the deadline: not "before"
    directed_rows.push_back('{poll(32'h800000D1, 1'b0, INIT_TIMEOUT, RD_OK,
                              words7(100, -200, 16384, 2500, -7, 3, -1)), 1'b0, '0});
    // now + fast delay wraps to exactly zero
    directed_rows.push_back('{poll(32'hFFFFFF9C, 1'b0, INIT_IO_ERR, RD_OK,
                              words7(100, -200, 16384, 2500, -7, 3, -1)), 1'b0, '0});
    // zero deadline: no wait, init succeeds, first sample
    directed_rows.push_back('{poll(32'd5, 1'b0, INIT_OK, RD_OK,
                              words7(100, -200, 16384, 2500, -7, 3, -1)),
                              1'b1, result_t'{ST_OK, 1'b1, STG_NONE, 32'd1, 32'd5,
                                              32'd0, 32'd5}});
    // values right at the limit pass; temp ignores the limit
    directed_rows.push_back('{poll(32'd6, 1'b0, INIT_OK, RD_OK,
                              words7(29500, -29500, 29500, -32768, -29500, 29500, -29500)),
                              1'b0, '0});
    directed_rows.push_back('{poll(32'd7, 1'b0, INIT_OK, RD_OK,
                              words7(29501, 0, 0, 0, 0, 0, 0)), 1'b0, '0});
    directed_rows.push_back('{poll(32'd8, 1'b0, INIT_OK, RD_OK,
                              words7(1, 1, 1, 1, 1, 1, -29501)), 1'b0, '0});
    // link failures: every read code, then zero frames up to the limit
    directed_rows.push_back('{poll(32'd9, 1'b0, INIT_OK, RD_TIMEOUT,
                              words7(1, 2, 3, 4, 5, 6, 7)), 1'b0, '0});
    directed_rows.push_back('{poll(32'd10, 1'b0, INIT_OK, RD_IO_ERR,
                              words7(1, 2, 3, 4, 5, 6, 7)), 1'b0, '0});
    directed_rows.push_back('{poll(32'd11, 1'b0, INIT_OK, RD_OTHER,
                              words7(1, 2, 3, 4, 5, 6, 7)), 1'b0, '0});
    directed_rows.push_back('{poll(32'd12, 1'b0, INIT_OK, RD_OK,
                              words7(0, 0, 0, 0, 0, 0, 0)), 1'b0, '0});
    directed_rows.push_back('{poll(32'd100, 1'b0, INIT_OK, RD_OK,
                              words7(0, 0, 0, 0, 0, 0, 0)), 1'b0, '0});
    // forced reinit waits out the fast delay
    directed_rows.push_back('{poll(32'd150, 1'b0, INIT_OK, RD_OK,
                              words7(1, 2, 3, 4, 5, 6, 7)), 1'b0, '0});
    directed_rows.push_back('{poll(32'd200, 1'b0, INIT_OK, RD_OK,
                              words7(1, 2, 3, 4, 5, 6, 7)), 1'b0, '0});
    // external reinit request
    directed_rows.push_back('{poll(32'd201, 1'b1, INIT_OK, RD_OK,
                              words7(1, 2, 3, 4, 5, 6, 7)), 1'b0, '0});
    directed_rows.push_back('{poll(32'd202, 1'b0, INIT_OK, RD_OK,
                              words7(32767, -32768, 0, 0, 0, 0, 0)), 1'b0, '0});
    // only temp nonzero: not a zero frame
    directed_rows.push_back('{poll(32'd203, 1'b0, INIT_OK, RD_OK,
                              words7(0, 0, 0, 32767, 0, 0, 0)), 1'b0, '0});
    directed_rows.push_back('{poll(32'hFFFFFFFF, 1'b0, INIT_OK, RD_OK,
                              words7(21845, -21846, 21845, -21846, 21845, -21846, 21845)),
                              1'b0, '0});
    directed_rows.push_back('{poll(32'd0, 1'b1, INIT_BAD_ID, RD_OK,
                              words7(1, 2, 3, 4, 5, 6, 7)), 1'b0, '0});
    directed_rows.push_back('{poll(32'd0, 1'b0, INIT_OK, RD_OK,
                              words7(1, 2, 3, 4, 5, 6, 7)), 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_poll(directed_rows[i].poll, directed_rows[i].typed, directed_rows[i].want);

    // fail limit zero, widest range, slow backoff after the first init failure
    drain();
    configure(8'd0, 16'd1, 16'hFFFF, 8'd0, 15'h7FFF);
    run_random(90);

    // highest fail limit and longest fast delay, zero range; no idling here
    drain();
    configure(8'd255, 16'hFFFF, 16'd1, 8'd255, 15'd0);
    quiet = 1'b1;
    run_random(90);
    quiet = 1'b0;

    // init failure storm: every init attempt fails, pushing the init failure count up
    drain();
    configure(8'd3, 16'd0, 16'd3, 8'd200, 15'd1000);
    init_storm = 1'b1;
    run_random(280);
    init_storm = 1'b0;

    drain();
    configure(8'($urandom_range(1, 8)), 16'($urandom_range(1, 2000)),
              16'($urandom_range(1, 2000)), 8'($urandom_range(0, 10)),
              15'($urandom_range(0, 32767)));
    run_random(90);

    drain();
    if (mismatches == 0) $display("imu_frame_health_monitor_unit: match");
    else $display("imu_frame_health_monitor_unit: mismatch");
    $finish;
  end

endmodule
